// ===== rtl/core/mcpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_pkg
// Shared types and constants of the mouse click and pause event extractor.
// ----------------------------------------------------------------------------
package mcpe_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int COORD_WIDTH_DEF = 16;

  // fixed widths of the stream fields
  localparam int OUT_TIME_W  = 32;
  localparam int OUT_COORD_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int DRAG_W      = 8;

  localparam logic [DRAG_W-1:0]     DRAG_DISTANCE_RST   = 8'd20;
  localparam logic [CFG_DATA_W-1:0] PAUSE_MIN_TIME_RST  = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_GAP_TIME_RST = 16'd500;

  // release and pause-end events found per sample, in emission order
  localparam int NUM_EV   = 3;
  localparam int EV_LEFT  = 0;
  localparam int EV_RIGHT = 1;
  localparam int EV_PAUSE = 2;

  localparam int MAX_RES = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  typedef enum logic [2:0] {
    KIND_LEFT      = 3'd0,
    KIND_RIGHT     = 3'd1,
    KIND_DRAG_DROP = 3'd2,
    KIND_DOUBLE    = 3'd3,
    KIND_PAUSE     = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAG_DISTANCE   = 2'd0,
    REG_PAUSE_MIN_TIME  = 2'd1,
    REG_DOUBLE_GAP_TIME = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [5:0]             pad;
    logic                   right_button;
    logic                   left_button;
    logic [OUT_COORD_W-1:0] pos_y;
    logic [OUT_COORD_W-1:0] pos_x;
    logic [OUT_TIME_W-1:0]  sample_time;
  } in_data_t;

  typedef struct packed {
    logic [OUT_TIME_W-1:0]  second_hold;
    logic [OUT_TIME_W-1:0]  between_gap;
    logic [OUT_TIME_W-1:0]  first_hold;
    logic [OUT_COORD_W-1:0] event_y;
    logic [OUT_COORD_W-1:0] event_x;
    logic [OUT_TIME_W-1:0]  event_length;
    logic [OUT_TIME_W-1:0]  event_start;
  } out_data_t;

  typedef struct packed {
    kind_t     kind;
    out_data_t data;
  } res_t;

  // candidate events of one sample, detect stage to merge stage
  typedef struct packed {
    logic vld;
    logic l_vld;
    logic r_vld;
    logic p_vld;
    logic eos;
  } cand_flags_t;

endpackage

// ===== rtl/core/mcpe_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_detect
// Button and stillness tracking; registers the release and pause candidates
// of each sample together with the squared travel of a left release.
// ----------------------------------------------------------------------------
module mcpe_detect #(
  parameter int TIME_WIDTH  = mcpe_pkg::TIME_WIDTH_DEF,
  parameter int COORD_WIDTH = mcpe_pkg::COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [TIME_WIDTH-1:0]                          in_time,
  input  logic [COORD_WIDTH-1:0]                         in_x,
  input  logic [COORD_WIDTH-1:0]                         in_y,
  input  logic                                           in_left,
  input  logic                                           in_right,
  input  logic                                           in_eos,
  input  logic [mcpe_pkg::CFG_DATA_W-1:0]                pause_min_time,
  input  logic                                           cand_take,
  output mcpe_pkg::cand_flags_t                          cand_flags,
  output logic [mcpe_pkg::NUM_EV-1:0][TIME_WIDTH-1:0]    ev_start,
  output logic [mcpe_pkg::NUM_EV-1:0][TIME_WIDTH-1:0]    ev_len,
  output logic [mcpe_pkg::NUM_EV-1:0][COORD_WIDTH-1:0]   ev_x,
  output logic [mcpe_pkg::NUM_EV-1:0][COORD_WIDTH-1:0]   ev_y,
  output logic [TIME_WIDTH-1:0]                          l_end,
  output logic [2*COORD_WIDTH-1:0]                       l_dx2,
  output logic [2*COORD_WIDTH-1:0]                       l_dy2
);
  import mcpe_pkg::*;

  logic                   left_down_r, right_down_r, paused_r;
  logic [TIME_WIDTH-1:0]  lp_time_r, rp_time_r, pb_time_r;
  logic [COORD_WIDTH-1:0] lp_x_r, lp_y_r, rp_x_r, rp_y_r, pb_x_r, pb_y_r;
  logic [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  cand_flags_t            flags_r;
  logic [NUM_EV-1:0][TIME_WIDTH-1:0]  start_r, len_r;
  logic [NUM_EV-1:0][COORD_WIDTH-1:0] x_r, y_r;
  logic [TIME_WIDTH-1:0]    l_end_r;
  logic [2*COORD_WIDTH-1:0] dx2_r, dy2_r;

  logic                   in_take;
  logic                   still;
  logic                   l_rel, r_rel, p_end;
  logic [TIME_WIDTH-1:0]  l_len, r_len, p_len;
  logic [COORD_WIDTH-1:0] dx, dy;

  assign in_ready = !flags_r.vld || cand_take;
  assign in_take  = in_valid && in_ready;

  assign still = !in_left && !in_right && (in_x == prev_x_r) && (in_y == prev_y_r);
  assign l_rel = !in_left && left_down_r;
  assign r_rel = !in_right && right_down_r;
  assign p_end = !still && paused_r;

  assign l_len = in_time - lp_time_r;
  assign r_len = in_time - rp_time_r;
  assign p_len = in_time - pb_time_r;

  assign dx = (in_x >= lp_x_r) ? (in_x - lp_x_r) : (lp_x_r - in_x);
  assign dy = (in_y >= lp_y_r) ? (in_y - lp_y_r) : (lp_y_r - in_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_down_r  <= 1'b0;
      right_down_r <= 1'b0;
      paused_r     <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      flags_r      <= '0;
    end else begin
      if (in_take) begin
        if (in_left && !left_down_r) begin
          lp_time_r <= in_time;
          lp_x_r    <= in_x;
          lp_y_r    <= in_y;
        end
        left_down_r <= in_left;
        if (in_right && !right_down_r) begin
          rp_time_r <= in_time;
          rp_x_r    <= in_x;
          rp_y_r    <= in_y;
        end
        right_down_r <= in_right;
        if (still && !paused_r) begin
          pb_time_r <= in_time;
          pb_x_r    <= in_x;
          pb_y_r    <= in_y;
        end
        paused_r <= still;
        prev_x_r <= in_x;
        prev_y_r <= in_y;

        flags_r.vld   <= 1'b1;
        flags_r.l_vld <= l_rel;
        flags_r.r_vld <= r_rel;
        flags_r.p_vld <= p_end && (p_len > TIME_WIDTH'(pause_min_time));
        flags_r.eos   <= in_eos;

        start_r[EV_LEFT]  <= lp_time_r;
        len_r[EV_LEFT]    <= l_len;
        x_r[EV_LEFT]      <= lp_x_r;
        y_r[EV_LEFT]      <= lp_y_r;
        start_r[EV_RIGHT] <= rp_time_r;
        len_r[EV_RIGHT]   <= r_len;
        x_r[EV_RIGHT]     <= rp_x_r;
        y_r[EV_RIGHT]     <= rp_y_r;
        start_r[EV_PAUSE] <= pb_time_r;
        len_r[EV_PAUSE]   <= p_len;
        x_r[EV_PAUSE]     <= pb_x_r;
        y_r[EV_PAUSE]     <= pb_y_r;
        l_end_r <= in_time;
        dx2_r   <= dx * dx;
        dy2_r   <= dy * dy;
      end else if (cand_take) begin
        flags_r.vld <= 1'b0;
      end
    end
  end

  assign cand_flags = flags_r;
  assign ev_start   = start_r;
  assign ev_len     = len_r;
  assign ev_x       = x_r;
  assign ev_y       = y_r;
  assign l_end      = l_end_r;
  assign l_dx2      = dx2_r;
  assign l_dy2      = dy2_r;

  a_still_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && still |=> paused_r && flags_r.vld)
    else $error("pause run not tracked after a still sample");

endmodule

// ===== rtl/core/mcpe_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_merge
// Drag classification and the one-slot left click stage that forms double
// clicks; builds the ordered result list of one sample.
// ----------------------------------------------------------------------------
module mcpe_merge #(
  parameter int TIME_WIDTH  = mcpe_pkg::TIME_WIDTH_DEF,
  parameter int COORD_WIDTH = mcpe_pkg::COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  mcpe_pkg::cand_flags_t                          cand_flags,
  input  logic [mcpe_pkg::NUM_EV-1:0][TIME_WIDTH-1:0]    ev_start,
  input  logic [mcpe_pkg::NUM_EV-1:0][TIME_WIDTH-1:0]    ev_len,
  input  logic [mcpe_pkg::NUM_EV-1:0][COORD_WIDTH-1:0]   ev_x,
  input  logic [mcpe_pkg::NUM_EV-1:0][COORD_WIDTH-1:0]   ev_y,
  input  logic [TIME_WIDTH-1:0]                          l_end,
  input  logic [2*COORD_WIDTH-1:0]                       l_dx2,
  input  logic [2*COORD_WIDTH-1:0]                       l_dy2,
  input  logic [mcpe_pkg::DRAG_W-1:0]                    drag_distance,
  input  logic [mcpe_pkg::CFG_DATA_W-1:0]                double_gap_time,
  input  logic                                           load_ready,
  output logic                                           cand_take,
  output mcpe_pkg::res_t [mcpe_pkg::MAX_RES-1:0]         res_list,
  output logic [mcpe_pkg::RES_CNT_W-1:0]                 res_cnt
);
  import mcpe_pkg::*;

  localparam int D2_W = 2 * COORD_WIDTH + 1;

  logic                   held_vld_r;
  logic [TIME_WIDTH-1:0]  held_start_r, held_len_r, held_end_r;
  logic [COORD_WIDTH-1:0] held_x_r, held_y_r;
  logic [2*DRAG_W-1:0]    drag_sq_r;

  logic [D2_W-1:0]        d2;
  logic                   is_drag;
  logic [TIME_WIDTH-1:0]  gap, dbl_len;
  logic                   hv;
  logic [TIME_WIDTH-1:0]  h_start, h_len, h_end;
  logic [COORD_WIDTH-1:0] h_x, h_y;
  res_t [MAX_RES-1:0]     list;
  logic [RES_CNT_W-1:0]   n;

  function automatic res_t mk_res(
    input kind_t                  k,
    input logic [TIME_WIDTH-1:0]  s,
    input logic [TIME_WIDTH-1:0]  l,
    input logic [COORD_WIDTH-1:0] x,
    input logic [COORD_WIDTH-1:0] y,
    input logic [TIME_WIDTH-1:0]  h1,
    input logic [TIME_WIDTH-1:0]  g,
    input logic [TIME_WIDTH-1:0]  h2
  );
    res_t r;
    r.kind              = k;
    r.data.event_start  = OUT_TIME_W'(s);
    r.data.event_length = OUT_TIME_W'(l);
    r.data.event_x      = OUT_COORD_W'(x);
    r.data.event_y      = OUT_COORD_W'(y);
    r.data.first_hold   = OUT_TIME_W'(h1);
    r.data.between_gap  = OUT_TIME_W'(g);
    r.data.second_hold  = OUT_TIME_W'(h2);
    return r;
  endfunction

  assign cand_take = cand_flags.vld && load_ready;

  assign d2      = D2_W'(l_dx2) + D2_W'(l_dy2);
  assign is_drag = d2 > D2_W'(drag_sq_r);
  // held end is the release time of the held click
  assign gap     = ev_start[EV_LEFT] - held_end_r;
  assign dbl_len = l_end - held_start_r;

  always_comb begin
    hv      = held_vld_r;
    h_start = held_start_r;
    h_len   = held_len_r;
    h_end   = held_end_r;
    h_x     = held_x_r;
    h_y     = held_y_r;
    list    = '0;
    n       = '0;

    if (cand_flags.l_vld) begin
      if (!is_drag && hv && (gap < TIME_WIDTH'(double_gap_time))) begin
        list[n[RES_IDX_W-1:0]] = mk_res(KIND_DOUBLE, held_start_r, dbl_len,
                                        ev_x[EV_LEFT], ev_y[EV_LEFT],
                                        held_len_r, gap, ev_len[EV_LEFT]);
        n  = n + 1'b1;
        hv = 1'b0;
      end else begin
        if (hv) begin
          list[n[RES_IDX_W-1:0]] = mk_res(KIND_LEFT, h_start, h_len, h_x, h_y,
                                          '0, '0, '0);
          n = n + 1'b1;
        end
        if (is_drag) begin
          list[n[RES_IDX_W-1:0]] = mk_res(KIND_DRAG_DROP, ev_start[EV_LEFT],
                                          ev_len[EV_LEFT], ev_x[EV_LEFT],
                                          ev_y[EV_LEFT], '0, '0, '0);
          n  = n + 1'b1;
          hv = 1'b0;
        end else begin
          hv      = 1'b1;
          h_start = ev_start[EV_LEFT];
          h_len   = ev_len[EV_LEFT];
          h_end   = l_end;
          h_x     = ev_x[EV_LEFT];
          h_y     = ev_y[EV_LEFT];
        end
      end
    end

    if (cand_flags.r_vld) begin
      if (hv) begin
        list[n[RES_IDX_W-1:0]] = mk_res(KIND_LEFT, h_start, h_len, h_x, h_y,
                                        '0, '0, '0);
        n  = n + 1'b1;
        hv = 1'b0;
      end
      list[n[RES_IDX_W-1:0]] = mk_res(KIND_RIGHT, ev_start[EV_RIGHT], ev_len[EV_RIGHT],
                                      ev_x[EV_RIGHT], ev_y[EV_RIGHT], '0, '0, '0);
      n = n + 1'b1;
    end

    if (cand_flags.p_vld) begin
      if (hv) begin
        list[n[RES_IDX_W-1:0]] = mk_res(KIND_LEFT, h_start, h_len, h_x, h_y,
                                        '0, '0, '0);
        n  = n + 1'b1;
        hv = 1'b0;
      end
      list[n[RES_IDX_W-1:0]] = mk_res(KIND_PAUSE, ev_start[EV_PAUSE], ev_len[EV_PAUSE],
                                      ev_x[EV_PAUSE], ev_y[EV_PAUSE], '0, '0, '0);
      n = n + 1'b1;
    end

    if (cand_flags.eos && hv) begin
      list[n[RES_IDX_W-1:0]] = mk_res(KIND_LEFT, h_start, h_len, h_x, h_y,
                                      '0, '0, '0);
      n  = n + 1'b1;
      hv = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
    end else begin
      drag_sq_r <= drag_distance * drag_distance;
      if (cand_take) begin
        held_vld_r   <= hv;
        held_start_r <= h_start;
        held_len_r   <= h_len;
        held_end_r   <= h_end;
        held_x_r     <= h_x;
        held_y_r     <= h_y;
      end
    end
  end

  assign res_list = list;
  assign res_cnt  = n;

  a_eos_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    cand_take && cand_flags.eos |=> !held_vld_r)
    else $error("held click survived end of stream");

  a_right_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    cand_take && (cand_flags.r_vld || cand_flags.p_vld) |=> !held_vld_r)
    else $error("held click survived a non-left event");

endmodule

// ===== rtl/core/mcpe_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_serial
// Result register: holds the result list of one sample and hands it out one
// transfer at a time, marking the last one.
// ----------------------------------------------------------------------------
module mcpe_serial (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   bundle_load,
  input  mcpe_pkg::res_t [mcpe_pkg::MAX_RES-1:0] res_list,
  input  logic [mcpe_pkg::RES_CNT_W-1:0]         res_cnt,
  output logic                                   load_ready,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output mcpe_pkg::out_data_t                    out_tdata,
  output logic [2:0]                             out_tuser,
  output logic                                   out_tlast
);
  import mcpe_pkg::*;

  res_t                 slot_r [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_IDX_W-1:0] idx_r;
  logic                 busy, last;
  res_t                 cur;

  assign busy = cnt_r != '0;
  assign last = RES_CNT_W'(idx_r) == (cnt_r - 1'b1);
  assign load_ready = !busy || (out_tready && last);
  assign cur = slot_r[idx_r];

  assign out_tvalid = busy;
  assign out_tdata  = cur.data;
  assign out_tuser  = cur.kind;
  assign out_tlast  = last;

  always_ff @(posedge clk) begin
    if (bundle_load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slot_r[i] <= res_list[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (bundle_load) begin
      cnt_r <= res_cnt;
      idx_r <= '0;
    end else if (busy && out_tready) begin
      if (last) begin
        cnt_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (RES_CNT_W'(idx_r) < cnt_r))
    else $error("result index past the list end");

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy && out_tready && !last && !bundle_load |=>
      out_tvalid && (idx_r == $past(idx_r) + 1'b1))
    else $error("result list did not advance after a transfer");

endmodule

// ===== rtl/core/mouse_click_pause_event_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_click_pause_event_extractor
// Turns a stream of mouse samples into click, drag-and-drop, double click and
// pause events.
// ----------------------------------------------------------------------------
// A sample that causes no event streams through at one per clock while the
// result register is empty. A sample that causes events (one to three)
// holds the input while they leave, one per transfer, from a four-entry
// result register; a following sample is loaded in the same cycle as the
// transfer of the last of them. A result passes the candidate register and
// then the result register before the output. Configuration writes are
// applied from registers and must happen while no events are pending.
module mouse_click_pause_event_extractor #(
  parameter int TIME_WIDTH  = mcpe_pkg::TIME_WIDTH_DEF,
  parameter int COORD_WIDTH = mcpe_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample_time, pos_x, pos_y, left_button, right_button, zero pad
  input  mcpe_pkg::in_data_t                 in_tdata,
  input  logic                               in_tlast,   // end_of_stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // event_start, event_length, event_x, event_y, first_hold, between_gap,
  // second_hold
  output mcpe_pkg::out_data_t                out_tdata,
  output logic [2:0]                         out_tuser,  // event_kind
  output logic                               out_tlast,  // last_of_run
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mcpe_pkg::*;

  logic [DRAG_W-1:0]     drag_distance_r;
  logic [CFG_DATA_W-1:0] pause_min_time_r;
  logic [CFG_DATA_W-1:0] double_gap_time_r;

  cand_flags_t                        cand_flags;
  logic [NUM_EV-1:0][TIME_WIDTH-1:0]  ev_start, ev_len;
  logic [NUM_EV-1:0][COORD_WIDTH-1:0] ev_x, ev_y;
  logic [TIME_WIDTH-1:0]              l_end;
  logic [2*COORD_WIDTH-1:0]           l_dx2, l_dy2;
  logic                               cand_take, load_ready;
  res_t [MAX_RES-1:0]                 res_list;
  logic [RES_CNT_W-1:0]               res_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_distance_r   <= DRAG_DISTANCE_RST;
      pause_min_time_r  <= PAUSE_MIN_TIME_RST;
      double_gap_time_r <= DOUBLE_GAP_TIME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRAG_DISTANCE:   drag_distance_r   <= cfg_data[DRAG_W-1:0];
        REG_PAUSE_MIN_TIME:  pause_min_time_r  <= cfg_data;
        REG_DOUBLE_GAP_TIME: double_gap_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mcpe_detect #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_detect (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_time        (TIME_WIDTH'(in_tdata.sample_time)),
    .in_x           (COORD_WIDTH'(in_tdata.pos_x)),
    .in_y           (COORD_WIDTH'(in_tdata.pos_y)),
    .in_left        (in_tdata.left_button),
    .in_right       (in_tdata.right_button),
    .in_eos         (in_tlast),
    .pause_min_time (pause_min_time_r),
    .cand_take      (cand_take),
    .cand_flags     (cand_flags),
    .ev_start       (ev_start),
    .ev_len         (ev_len),
    .ev_x           (ev_x),
    .ev_y           (ev_y),
    .l_end          (l_end),
    .l_dx2          (l_dx2),
    .l_dy2          (l_dy2)
  );

  mcpe_merge #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .cand_flags      (cand_flags),
    .ev_start        (ev_start),
    .ev_len          (ev_len),
    .ev_x            (ev_x),
    .ev_y            (ev_y),
    .l_end           (l_end),
    .l_dx2           (l_dx2),
    .l_dy2           (l_dy2),
    .drag_distance   (drag_distance_r),
    .double_gap_time (double_gap_time_r),
    .load_ready      (load_ready),
    .cand_take       (cand_take),
    .res_list        (res_list),
    .res_cnt         (res_cnt)
  );

  mcpe_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle_load (cand_take),
    .res_list    (res_list),
    .res_cnt     (res_cnt),
    .load_ready  (load_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== verif/tb_mouse_click_pause_event_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_click_pause_event_extractor
// Streams mouse samples into the extractor and checks every event it gives
// against an event predictor kept in the bench. A directed opening covers
// clicks, double clicks, drags, pauses, end flushes and time wrap; random
// gesture sequences follow under several register settings, with bursty
// input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_mouse_click_pause_event_extractor;
  import mcpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    kind_t     kind;
    out_data_t data;
    logic      last;
  } mouse_event_t;

  // event predictor and the queue of events still owed by the block
  class mouse_event_board;
    logic [7:0]   drag_dist;
    logic [15:0]  pause_min, dbl_gap;
    logic         left_down, right_down, paused, held_valid;
    logic [31:0]  left_t, right_t, pause_t, held_start, held_len;
    logic [15:0]  left_x, left_y, right_x, right_y, pause_x, pause_y;
    logic [15:0]  prev_x, prev_y, held_x, held_y;
    mouse_event_t events_due[$];
    mouse_event_t run_events[$];
    int           mismatches, checked;
    int           kind_seen[5];

    function new();
      drag_dist = DRAG_DISTANCE_RST;
      pause_min = PAUSE_MIN_TIME_RST;
      dbl_gap = DOUBLE_GAP_TIME_RST;
      {left_down, right_down, paused, held_valid} = '0;
      {left_t, right_t, pause_t, held_start, held_len} = '0;
      {left_x, left_y, right_x, right_y, pause_x, pause_y} = '0;
      {prev_x, prev_y, held_x, held_y} = '0;
      mismatches = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_DRAG_DISTANCE: drag_dist = val[7:0];
        REG_PAUSE_MIN_TIME: pause_min = val;
        REG_DOUBLE_GAP_TIME: dbl_gap = val;
        default: ;
      endcase
    endfunction

    function mouse_event_t make_event(kind_t k, logic [31:0] st, logic [31:0] len,
                                      logic [15:0] x, logic [15:0] y, logic [31:0] h1,
                                      logic [31:0] gap, logic [31:0] h2);
      mouse_event_t e;
      e.kind = k;
      e.data.event_start = st;
      e.data.event_length = len;
      e.data.event_x = x;
      e.data.event_y = y;
      e.data.first_hold = h1;
      e.data.between_gap = gap;
      e.data.second_hold = h2;
      e.last = 1'b0;
      return e;
    endfunction

    function void flush_held();
      if (held_valid) begin
        held_valid = 1'b0;
        run_events.insert(run_events.size(),
                          make_event(KIND_LEFT, held_start, held_len, held_x, held_y,
                                     '0, '0, '0));
      end
    endfunction

    // one-slot stage: a left click waits here for a possible partner
    function void stage(mouse_event_t e);
      logic [31:0] gap;
      if (e.kind == KIND_LEFT) begin
        if (held_valid) begin
          gap = e.data.event_start - (held_start + held_len);
          if (gap < {16'd0, dbl_gap}) begin
            held_valid = 1'b0;
            run_events.insert(run_events.size(),
                              make_event(KIND_DOUBLE, held_start,
                                         held_len + gap + e.data.event_length,
                                         e.data.event_x, e.data.event_y,
                                         held_len, gap, e.data.event_length));
            return;
          end
          flush_held();
        end
        held_valid = 1'b1;
        held_start = e.data.event_start;
        held_len = e.data.event_length;
        held_x = e.data.event_x;
        held_y = e.data.event_y;
      end else begin
        flush_held();
        run_events.insert(run_events.size(), e);
      end
    endfunction

    function void take_sample(in_data_t s, logic eos);
      logic [31:0]     t, len;
      logic [15:0]     x, y;
      logic            lb, rb;
      longint          dx, dy;
      longint unsigned d2, reach;
      kind_t           k;
      t = s.sample_time;
      x = s.pos_x;
      y = s.pos_y;
      lb = s.left_button;
      rb = s.right_button;
      run_events.delete();

      if (lb) begin
        if (!left_down) begin
          left_t = t;
          left_x = x;
          left_y = y;
        end
        left_down = 1'b1;
      end else if (left_down) begin
        dx = longint'(x) - longint'(left_x);
        dy = longint'(y) - longint'(left_y);
        d2 = dx * dx + dy * dy;
        reach = longint'(drag_dist) * longint'(drag_dist);
        left_down = 1'b0;
        k = (d2 > reach) ? KIND_DRAG_DROP : KIND_LEFT;
        stage(make_event(k, left_t, t - left_t, left_x, left_y, '0, '0, '0));
      end

      if (rb) begin
        if (!right_down) begin
          right_t = t;
          right_x = x;
          right_y = y;
        end
        right_down = 1'b1;
      end else if (right_down) begin
        right_down = 1'b0;
        stage(make_event(KIND_RIGHT, right_t, t - right_t, right_x, right_y, '0, '0, '0));
      end

      if (!lb && !rb && x == prev_x && y == prev_y) begin
        if (!paused) begin
          pause_t = t;
          pause_x = x;
          pause_y = y;
        end
        paused = 1'b1;
      end else if (paused) begin
        len = t - pause_t;
        paused = 1'b0;
        if (len > {16'd0, pause_min})
          stage(make_event(KIND_PAUSE, pause_t, len, pause_x, pause_y, '0, '0, '0));
      end
      prev_x = x;
      prev_y = y;

      if (eos) flush_held();

      if (run_events.size() > 0) run_events[run_events.size() - 1].last = 1'b1;
      foreach (run_events[i]) events_due.insert(events_due.size(), run_events[i]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("event %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_event(kind_t k, out_data_t d, logic last);
      mouse_event_t w;
      if (events_due.size() == 0) begin
        report_mismatch($sformatf("event of kind %0d start %0h with nothing due", k,
                                  d.event_start));
        return;
      end
      w = events_due.pop_front();
      checked++;
      kind_seen[int'(w.kind)]++;
      compare_field("kind", 32'(k), 32'(w.kind));
      compare_field("event_start", d.event_start, w.data.event_start);
      compare_field("event_length", d.event_length, w.data.event_length);
      compare_field("event_x", 32'(d.event_x), 32'(w.data.event_x));
      compare_field("event_y", 32'(d.event_y), 32'(w.data.event_y));
      compare_field("first_hold", d.first_hold, w.data.first_hold);
      compare_field("between_gap", d.between_gap, w.data.between_gap);
      compare_field("second_hold", d.second_hold, w.data.second_hold);
      compare_field("last_of_run", 32'(last), 32'(w.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  in_data_t              in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  out_data_t             out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mouse_event_board sb;
  int unsigned      burst_left = 0;
  int unsigned      samples_sent = 0;
  int unsigned      settings_used = 1;
  int unsigned      cycle_count = 0;
  int unsigned      rx_left = 0;
  int unsigned      rx_mode = 0;
  int unsigned      stall_left = 0;
  logic [31:0]      cur_t = '0;
  logic [15:0]      cur_x = '0;
  logic [15:0]      cur_y = '0;

  mouse_click_pause_event_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_count,
               sb.events_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: modes of steady, random and long stalls, switched now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(40, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left <= $urandom_range(2, 12);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // values seen at the falling edge are the ones the next rising edge takes
  always @(negedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_event(kind_t'(out_tuser), out_tdata, out_tlast);
  end

  task automatic send(logic [31:0] t, logic [15:0] x, logic [15:0] y, logic lb, logic rb,
                      logic eos);
    in_data_t s;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    s = '0;
    s.sample_time = t;
    s.pos_x = x;
    s.pos_y = y;
    s.left_button = lb;
    s.right_button = rb;
    in_tdata <= s;
    in_tlast <= eos;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (in_tready !== 1'b1);
    @(posedge clk);
    sb.take_sample(s, eos);
    samples_sent++;
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic tx(logic lb, logic rb);
    send(cur_t, cur_x, cur_y, lb, rb, $urandom_range(0, 19) == 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val, logic closing);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    sb.set_reg(idx, val);
    if (closing) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [7:0] drag, logic [15:0] pmin, logic [15:0] dgap);
    write_reg(REG_DRAG_DISTANCE, {8'd0, drag}, 1'b0);
    write_reg(REG_PAUSE_MIN_TIME, pmin, 1'b0);
    write_reg(REG_DOUBLE_GAP_TIME, dgap, 1'b1);
    settings_used++;
  endtask

  // a sample without events may still be in flight, so linger after the queue drains
  task automatic wait_idle();
    if (burst_left != 0) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (sb.events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned around(int unsigned lim);
    case ($urandom_range(0, 3))
      0: return (lim == 0) ? 0 : lim - 1;
      1: return lim;
      2: return lim + 1;
      default: return $urandom_range(0, 2 * lim + 2);
    endcase
  endfunction

  task automatic button_click(logic is_left, int unsigned travel);
    logic [15:0] px, py;
    if ($urandom_range(0, 1)) begin
      cur_x = 16'($urandom);
      cur_y = 16'($urandom);
    end
    px = cur_x;
    py = cur_y;
    tx(is_left, !is_left);
    repeat ($urandom_range(0, 2)) begin
      cur_t += $urandom_range(0, 200);
      cur_x += 16'($urandom_range(0, 2));
      tx(is_left, !is_left);
    end
    cur_t += $urandom_range(0, 400);
    // straight moves cover exactly the given travel
    if ($urandom_range(0, 2) == 0) begin
      cur_x = px - 16'(travel);
      cur_y = py;
    end else begin
      cur_x = px + 16'($urandom_range(0, travel));
      cur_y = py - 16'($urandom_range(0, travel));
    end
    tx(1'b0, 1'b0);
  endtask

  task automatic still_run();
    int unsigned n, dur;
    logic [31:0] t0;
    n = $urandom_range(1, 4);
    dur = around(sb.pause_min);
    cur_x += 16'd1;
    tx(1'b0, 1'b0);
    cur_t += $urandom_range(0, 100);
    t0 = cur_t;
    tx(1'b0, 1'b0);
    repeat (n - 1) begin
      cur_t += dur / n;
      tx(1'b0, 1'b0);
    end
    cur_t = t0 + dur;
    cur_y += 16'd1;
    tx(1'b0, 1'b0);
  endtask

  task automatic random_episode();
    case ($urandom_range(0, 11))
      0, 1, 2: button_click(1'b1, $urandom_range(0, sb.drag_dist));
      3, 4: begin
        button_click(1'b1, $urandom_range(0, sb.drag_dist));
        cur_t += around(sb.dbl_gap);
        button_click(1'b1, $urandom_range(0, sb.drag_dist));
      end
      5: button_click(1'b1, $urandom_range(0, 1) ? sb.drag_dist + $urandom_range(0, 1)
                                                 : $urandom_range(0, 65535));
      6: button_click(1'b0, $urandom_range(0, 300));
      7, 8: still_run();
      9: begin
        repeat ($urandom_range(2, 5)) begin
          cur_t += $urandom_range(0, 300);
          cur_x += 16'($urandom_range(0, 1));
          tx(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      default: begin
        // broken sequences, with time free to jump back or wrap
        if ($urandom_range(0, 3) == 0) cur_t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else cur_t = $urandom;
        cur_x = 16'($urandom);
        cur_y = 16'($urandom);
        tx(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned goal;
    goal = samples_sent + count;
    while (samples_sent < goal) random_episode();
  endtask

  task automatic directed_samples();
    // button-free first sample at the origin opens a still run
    send(32'd100, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    send(32'd6000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    send(32'd6200, 16'd10, 16'd10, 1'b0, 1'b0, 1'b0);
    // quick left pair merges, then a third and fourth pair again
    send(32'd7000, 16'd10, 16'd10, 1'b1, 1'b0, 1'b0);
    send(32'd7100, 16'd13, 16'd14, 1'b0, 1'b0, 1'b0);
    send(32'd7300, 16'd10, 16'd10, 1'b1, 1'b0, 1'b0);
    send(32'd7350, 16'd10, 16'd10, 1'b0, 1'b0, 1'b0);
    send(32'd7400, 16'd20, 16'd20, 1'b1, 1'b0, 1'b0);
    send(32'd7450, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0);
    send(32'd7500, 16'd20, 16'd20, 1'b1, 1'b0, 1'b0);
    send(32'd7550, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0);
    // right click pushes out a waiting left click
    send(32'd8000, 16'd30, 16'd30, 1'b1, 1'b0, 1'b0);
    send(32'd8010, 16'd30, 16'd30, 1'b0, 1'b0, 1'b0);
    send(32'd8020, 16'd30, 16'd30, 1'b0, 1'b1, 1'b0);
    send(32'd8100, 16'd30, 16'd30, 1'b0, 1'b0, 1'b0);
    // long drag, then a click flushed by the end flag
    send(32'd9000, 16'd100, 16'd100, 1'b1, 1'b0, 1'b0);
    send(32'd9100, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b1);
    send(32'd9200, 16'd5, 16'd5, 1'b1, 1'b0, 1'b0);
    send(32'd9210, 16'd5, 16'd5, 1'b0, 1'b0, 1'b1);
    // both buttons across the time wrap at the far corner
    send(32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send(32'h0000_0010, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    // time steps back, so the gap wraps and the clicks stay apart
    send(32'd50, 16'd7, 16'd7, 1'b1, 1'b0, 1'b0);
    send(32'd60, 16'd7, 16'd7, 1'b0, 1'b0, 1'b0);
    send(32'd40, 16'd7, 16'd7, 1'b1, 1'b0, 1'b0);
    send(32'd45, 16'd7, 16'd7, 1'b0, 1'b0, 1'b0);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_samples();
    random_phase(38);
    wait_idle();
    program_regs(8'd0, 16'd0, 16'd0);
    random_phase(38);
    wait_idle();
    program_regs(8'd255, 16'hFFFF, 16'hFFFF);
    random_phase(38);
    wait_idle();
    program_regs(8'($urandom), 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1000)));
    random_phase(38);
    wait_idle();
    program_regs(8'd20, 16'd300, 16'd150);
    random_phase(38);
    wait_idle();
    $display("%0d samples under %0d register settings, %0d events compared",
             samples_sent, settings_used, sb.checked);
    $display("events by kind: left %0d right %0d drag %0d double %0d pause %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
